>>> hw/rtl/irsbpf_pkg.sv
// types and constants shared by the ir sample byte packet framer
`timescale 1ns / 1ps

package irsbpf_pkg;

    localparam logic       OP_SAMPLE  = 1'b0;
    localparam logic       OP_TIMEOUT = 1'b1;

    localparam logic [1:0] KIND_PULSE = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [15:0] END_WIDTH = 16'hFFFF;
    localparam logic [7:0]  LONE_BYTE = 8'hFF;
    localparam logic [7:0]  GAP_RESET = 8'd8;

    typedef struct packed {
        logic       op;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic        level;
        logic [15:0] width;
        logic        first_in_packet;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  held_byte;
        logic        held_byte_valid;
        logic        current_level;
        logic        packet_open;
        logic [15:0] previous_width;
        logic        previous_width_valid;
        logic        ended_on_timeout;
    } t_state;

endpackage

>>> hw/rtl/irsbpf_step.sv
// next-state and result logic for one item of the framer
`timescale 1ns / 1ps

module irsbpf_step (
    input  irsbpf_pkg::t_state    i_state,
    input  irsbpf_pkg::t_in_item  i_item,
    input  logic [7:0]            i_gap_factor,
    output irsbpf_pkg::t_state    o_state,
    output logic                  o_res_valid,
    output irsbpf_pkg::t_out_item o_res
);

    logic [15:0] w;
    logic [23:0] threshold;
    logic        lvl;
    logic        after_timeout;

    assign w         = {i_state.held_byte, i_item.byte_value};
    assign threshold = 24'(i_gap_factor) * 24'(i_state.previous_width);
    assign lvl       = !i_state.current_level;

    always_comb begin
        o_state       = i_state;
        o_res_valid   = 1'b0;
        o_res         = '0;
        after_timeout = i_state.ended_on_timeout;
        if (i_item.op == irsbpf_pkg::OP_TIMEOUT) begin
            if (i_state.packet_open) begin
                o_state.packet_open = 1'b0;
                o_res_valid         = 1'b1;
                o_res.kind          = irsbpf_pkg::KIND_END;
            end
            o_state.ended_on_timeout = 1'b1;
            if (i_state.held_byte_valid && i_state.held_byte == irsbpf_pkg::LONE_BYTE) begin
                o_state.held_byte_valid = 1'b0;
            end
        end else if (!i_state.held_byte_valid) begin
            o_state.held_byte       = i_item.byte_value;
            o_state.held_byte_valid = 1'b1;
        end else begin
            o_state.held_byte_valid  = 1'b0;
            o_state.ended_on_timeout = 1'b0;
            if (w == irsbpf_pkg::END_WIDTH) begin
                o_state.current_level = 1'b0;
                if (i_state.packet_open) begin
                    o_state.packet_open = 1'b0;
                    o_res_valid         = 1'b1;
                    o_res.kind          = irsbpf_pkg::KIND_END;
                end
            end else begin
                o_state.current_level = lvl;
                if (!lvl && (!i_state.previous_width_valid || 24'(w) > threshold)) begin
                    // gap between packets
                    if (!after_timeout) begin
                        o_res_valid = 1'b1;
                        if (!i_state.packet_open) begin
                            o_res.kind = irsbpf_pkg::KIND_ERROR;
                        end else begin
                            o_state.packet_open = 1'b0;
                            o_res.kind          = irsbpf_pkg::KIND_END;
                        end
                    end
                end else begin
                    o_state.packet_open          = 1'b1;
                    o_state.previous_width       = w;
                    o_state.previous_width_valid = 1'b1;
                    o_res_valid                  = 1'b1;
                    o_res.kind                   = irsbpf_pkg::KIND_PULSE;
                    o_res.level                  = lvl;
                    o_res.width                  = w;
                    o_res.first_in_packet        = !i_state.packet_open;
                end
            end
        end
    end

endmodule

>>> hw/rtl/ir_sample_byte_packet_framer.sv
// top level of the ir sample byte packet framer
// stages: an accepted item is held in r_in; its result enters r_out once r_out is free
// throughput: one item per cycle while the output is not stalled, bounded by the
//   combinational state update (pairing, level toggle, gap_factor x width compare)
// reset: synchronous active-low, clears all state and both stages, gap_factor to 8
`timescale 1ns / 1ps

module ir_sample_byte_packet_framer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  irsbpf_pkg::t_in_item  i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output irsbpf_pkg::t_out_item o_out,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_data
);

    logic                  r_in_valid;
    irsbpf_pkg::t_in_item  r_in;
    logic                  r_out_valid;
    irsbpf_pkg::t_out_item r_out;
    irsbpf_pkg::t_state    r_state;
    irsbpf_pkg::t_state    n_state;
    logic [7:0]            r_gap_factor;
    logic                  n_res_valid;
    irsbpf_pkg::t_out_item n_res;
    logic                  out_free;
    logic                  advance;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    irsbpf_step u_step (
        .i_state      (r_state),
        .i_item       (r_in),
        .i_gap_factor (r_gap_factor),
        .o_state      (n_state),
        .o_res_valid  (n_res_valid),
        .o_res        (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= '0;
            r_gap_factor <= irsbpf_pkg::GAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_gap_factor <= i_cfg_data;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= advance && n_res_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in;
        end
        if (advance && n_res_valid) begin
            r_out <= n_res;
        end
    end

    a_non_pulse_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind != irsbpf_pkg::KIND_PULSE
        |-> o_out.width == 16'd0 && !o_out.level && !o_out.first_in_packet)
        else $error("non-pulse result carries pulse fields");

    a_pulse_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind == irsbpf_pkg::KIND_PULSE
        |-> o_out.width != irsbpf_pkg::END_WIDTH)
        else $error("end marker width emitted as pulse");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled without a blocked result");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_in_valid && !r_out_valid)
        else $error("stages not empty after reset");

endmodule
